/* hw/rtl/crrt_pkg.sv */
// Package for the checked request responder with tone.
// Holds shared constants, register codes, queue entry types and state enums.
// No dependencies.
`timescale 1ns / 1ps

package crrt_pkg;

  // Queue depths (defaults for the top-level parameters)
  localparam int unsigned CmdDepthDef = 2;
  localparam int unsigned OutDepthDef = 4;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Divider width and register reset values
  localparam int unsigned DivW          = 16;
  localparam logic [7:0]  HdrFirstRst   = 8'hBB;
  localparam logic [7:0]  HdrSecondRst  = 8'hCC;
  localparam logic [7:0]  RplFirstRst   = 8'hAA;
  localparam logic [7:0]  RplSecondRst  = 8'hCC;
  localparam logic [15:0] TickRateRst   = 16'd10000;

  // Request count and tick counter both wrap at this value
  localparam logic [7:0]  CountWrap     = 8'd254;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HEADER_FIRST  = 3'd0,
    REG_HEADER_SECOND = 3'd1,
    REG_REPLY_FIRST   = 3'd2,
    REG_REPLY_SECOND  = 3'd3,
    REG_TICK_RATE     = 3'd4
  } cfg_reg_t;

  // Classified request from the front end
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_NOREQ = 2'd1,
    CMD_REQ   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] freq;
  } cmd_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
    logic       speaker;
  } result_t;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
  } hdr_cfg_t;

  typedef struct packed {
    logic [7:0]  reply_first;
    logic [7:0]  reply_second;
    logic [15:0] tick_rate;
  } rsp_cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_EMIT = 2'd2
  } back_state_t;

endpackage

/* hw/rtl/crrt_fifo.sv */
// Small register-based FIFO used for the request queue and the result queue.
// Generic in width and depth; no package dependencies.
`timescale 1ns / 1ps

module crrt_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CntW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* hw/rtl/crrt_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on crrt_pkg for the operand width.
`timescale 1ns / 1ps

module crrt_div
  import crrt_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [DivW-1:0] dividend,
  input  logic [DivW-1:0] divisor,
  output logic            done,
  output logic [DivW-1:0] quotient
);

  localparam int unsigned StepW = $clog2(DivW);

  logic [DivW-1:0]  quo_r, quo_nxt;
  logic [DivW-1:0]  rem_r, rem_nxt;
  logic [DivW-1:0]  dsr_r, dsr_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DivW:0]    shifted, trial;

  assign done     = done_r;
  assign quotient = quo_r;

  // Shift in the next dividend bit and try a subtract
  assign shifted = {rem_r, quo_r[DivW-1]};
  assign trial   = shifted - {1'b0, dsr_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DivW]) begin
        rem_nxt = trial[DivW-1:0];
        quo_nxt = {quo_r[DivW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DivW-1:0];
        quo_nxt = {quo_r[DivW-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == StepW'(DivW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

endmodule

/* hw/rtl/crrt_front.sv */
// Front end: receive window and request classification.
// Depends on crrt_pkg; feeds the request queue.
`timescale 1ns / 1ps

module crrt_front
  import crrt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic       command,
  input  logic [7:0] rx_byte,
  input  hdr_cfg_t   hdr_cfg,
  output logic       cmd_push,
  output cmd_t       cmd_data
);

  // Oldest byte at index 0
  logic [7:0] win_r   [4];
  logic [7:0] win_nxt [4];
  logic [7:0] sum;
  logic       is_req;

  assign sum    = win_r[0] + win_r[1] + win_r[2] + win_r[3];
  assign is_req = (win_r[0] == hdr_cfg.header_first) &&
                  (win_r[1] == hdr_cfg.header_second) &&
                  (rx_byte == sum);

  // Classify the incoming item
  always_comb begin
    cmd_push      = accept;
    cmd_data.freq = {win_r[3], win_r[2]};
    if (command) begin
      cmd_data.kind = CMD_TICK;
    end else if (is_req) begin
      cmd_data.kind = CMD_REQ;
    end else begin
      cmd_data.kind = CMD_NOREQ;
    end
  end

  // Slide the window on every received byte
  always_comb begin
    win_nxt = win_r;
    if (accept && !command) begin
      win_nxt[0] = win_r[1];
      win_nxt[1] = win_r[2];
      win_nxt[2] = win_r[3];
      win_nxt[3] = rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '{default: 8'd0};
    end else begin
      win_r <= win_nxt;
    end
  end

endmodule

/* hw/rtl/crrt_back.sv */
// Back end: carries out ticks and requests, owns the tone and reply state.
// Depends on crrt_pkg and crrt_div; drains the request queue into the result queue.
`timescale 1ns / 1ps

module crrt_back
  import crrt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  rsp_cfg_t rsp_cfg,
  input  logic     cmd_empty,
  input  cmd_t     cmd_data,
  output logic     cmd_pop,
  input  logic     res_full,
  output logic     res_push,
  output result_t  res_data
);

  back_state_t state_r, state_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  rcnt_r, rcnt_nxt;
  logic [7:0]  half_r, half_nxt;
  logic [7:0]  tick_r, tick_nxt;
  logic        spk_r, spk_nxt;
  logic        fzero_r, fzero_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [7:0]  count_inc, tick_inc, chk;
  logic        tick_hit;
  logic        div_start, div_done;
  logic [DivW-1:0] div_quo;

  crrt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rsp_cfg.tick_rate),
    .divisor  (cmd_data.freq),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign count_inc = count_r + 8'd1;
  assign tick_hit  = (half_r != 8'd0) && (tick_r == half_r);
  assign tick_inc  = tick_hit ? 8'd1 : tick_r + 8'd1;
  assign chk       = rsp_cfg.reply_first + rsp_cfg.reply_second + rcnt_r;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    rcnt_nxt  = rcnt_r;
    half_nxt  = half_r;
    tick_nxt  = tick_r;
    spk_nxt   = spk_r;
    fzero_nxt = fzero_r;
    idx_nxt   = idx_r;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    res_data  = '{tx_valid: 1'b0, tx_byte: 8'd0, last: 1'b1, speaker: spk_r};
    div_start = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          case (cmd_data.kind)
            CMD_TICK: begin
              // Toggle on a match, counter runs 1..253
              spk_nxt          = tick_hit ? !spk_r : spk_r;
              tick_nxt         = (tick_inc >= CountWrap) ? 8'd1 : tick_inc;
              res_push         = 1'b1;
              res_data.speaker = spk_nxt;
            end
            CMD_REQ: begin
              rcnt_nxt  = count_inc;
              count_nxt = (count_inc >= CountWrap) ? 8'd0 : count_inc;
              fzero_nxt = (cmd_data.freq == 16'd0);
              div_start = 1'b1;
              state_nxt = BK_DIV;
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      BK_DIV: begin
        if (div_done) begin
          half_nxt  = fzero_r ? 8'd0 : div_quo[7:0];
          idx_nxt   = 2'd0;
          state_nxt = BK_EMIT;
        end
      end
      BK_EMIT: begin
        // Four reply bytes, last on the checksum
        if (!res_full) begin
          res_push          = 1'b1;
          res_data.tx_valid = 1'b1;
          res_data.last     = (idx_r == 2'd3);
          case (idx_r)
            2'd0:    res_data.tx_byte = rsp_cfg.reply_first;
            2'd1:    res_data.tx_byte = rsp_cfg.reply_second;
            2'd2:    res_data.tx_byte = rcnt_r;
            default: res_data.tx_byte = chk;
          endcase
          idx_nxt = idx_r + 2'd1;
          if (idx_r == 2'd3) begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      count_r <= 8'd0;
      half_r  <= 8'd0;
      tick_r  <= 8'd1;
      spk_r   <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      half_r  <= half_nxt;
      tick_r  <= tick_nxt;
      spk_r   <= spk_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rcnt_r  <= rcnt_nxt;
    fzero_r <= fzero_nxt;
  end

endmodule

/* hw/rtl/checked_request_responder_with_tone_core.sv */
// Top level of the checked request responder with tone.
// Depends on crrt_pkg, crrt_fifo, crrt_front and crrt_back.
`timescale 1ns / 1ps

// Accepts received bytes and timer ticks through a queue-style input and
// returns results through a queue-style output. A tick or a byte that does
// not complete a request gives one result; a valid request gives four reply
// results and occupies the back end for a bit-serial divide of tick_rate by
// the requested frequency followed by one reply byte per cycle while the
// result queue has room. A request queue of CmdDepth entries lets the input
// keep taking items while the back end works, and a result queue of OutDepth
// entries holds finished results until they are popped. Configuration writes
// are always ready and must be made while the block is idle.
module checked_request_responder_with_tone_core
  import crrt_pkg::*;
#(
  parameter int unsigned CmdDepth = CmdDepthDef,
  parameter int unsigned OutDepth = OutDepthDef
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_push,
  output logic                in_full,
  input  logic                in_command,
  input  logic [7:0]          in_rx_byte,
  // result channel
  output logic                out_empty,
  input  logic                out_pop,
  output logic                out_tx_valid,
  output logic [7:0]          out_tx_byte,
  output logic                out_last,
  output logic                out_speaker,
  // configuration
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  hdr_cfg_t hdr_cfg_r, hdr_cfg_nxt;
  rsp_cfg_t rsp_cfg_r, rsp_cfg_nxt;
  logic     in_accept;
  logic     cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t     cmd_wdata, cmd_rdata;
  logic     res_push, res_full;
  result_t  res_wdata, res_rdata;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    hdr_cfg_nxt = hdr_cfg_r;
    rsp_cfg_nxt = rsp_cfg_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_HEADER_FIRST:  hdr_cfg_nxt.header_first  = cfg_data[7:0];
        REG_HEADER_SECOND: hdr_cfg_nxt.header_second = cfg_data[7:0];
        REG_REPLY_FIRST:   rsp_cfg_nxt.reply_first   = cfg_data[7:0];
        REG_REPLY_SECOND:  rsp_cfg_nxt.reply_second  = cfg_data[7:0];
        REG_TICK_RATE:     rsp_cfg_nxt.tick_rate     = cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cfg_r <= '{header_first: HdrFirstRst, header_second: HdrSecondRst};
      rsp_cfg_r <= '{reply_first: RplFirstRst, reply_second: RplSecondRst,
                     tick_rate: TickRateRst};
    end else begin
      hdr_cfg_r <= hdr_cfg_nxt;
      rsp_cfg_r <= rsp_cfg_nxt;
    end
  end

  // Front end
  assign in_full   = cmd_full;
  assign in_accept = in_push && !cmd_full;

  crrt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .command  (in_command),
    .rx_byte  (in_rx_byte),
    .hdr_cfg  (hdr_cfg_r),
    .cmd_push (cmd_push),
    .cmd_data (cmd_wdata)
  );

  // Request queue between front and back
  crrt_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CmdDepth)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_wdata),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  // Back end
  crrt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_cfg   (rsp_cfg_r),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_rdata),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_wdata)
  );

  // Result queue
  crrt_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OutDepth)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty)
  );

  assign out_tx_valid = res_rdata.tx_valid;
  assign out_tx_byte  = res_rdata.tx_byte;
  assign out_last     = res_rdata.last;
  assign out_speaker  = res_rdata.speaker;

endmodule
